// ===== hdl/signed_int_to_decimal_ascii_assert.svh =====
// Assertion macros shared by the RTL; each use sits on a line of its own.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIDTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SIDTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sidta_pkg.sv =====
package sidta_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Conversion: 32 double-dabble shifts from the accepted input beat, one bit per cycle,
// then leading zeros are skipped one per cycle before the first character is offered.
// The input is taken only when the previous text has been fully delivered.
// Reset: synchronous, active high; returns to idle and drops any run in progress.
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sidta_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [sidta_pkg::CHAR_W-1:0]  char_code,
  output logic                                last
);

  sidta_pkg::state_t state, state_next;

  logic [sidta_pkg::VALUE_W-1:0]   bin, bin_next;
  logic [sidta_pkg::BCD_W-1:0]     bcd, bcd_next;
  logic [sidta_pkg::BCD_W-1:0]     bcd_adj;
  logic                            neg, neg_next;
  logic [sidta_pkg::BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [sidta_pkg::DIG_CNT_W-1:0] dig_cnt, dig_cnt_next;
  logic [3:0]                      top_digit;
  logic [sidta_pkg::VALUE_W-1:0]   raw;

  assign raw       = $unsigned(value);
  assign top_digit = bcd[sidta_pkg::BCD_W-1 -: 4];

  // add-3 correction, every BCD lane on its own
  always_comb begin
    for (int i = 0; i < sidta_pkg::NUM_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sidta_pkg::ST_IDLE;
      neg     <= 1'b0;
      bit_cnt <= '0;
      dig_cnt <= '0;
    end else begin
      state   <= state_next;
      neg     <= neg_next;
      bit_cnt <= bit_cnt_next;
      dig_cnt <= dig_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    bin <= bin_next;
    bcd <= bcd_next;
  end

  always_comb begin
    state_next   = state;
    bin_next     = bin;
    bcd_next     = bcd;
    neg_next     = neg;
    bit_cnt_next = bit_cnt;
    dig_cnt_next = dig_cnt;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    char_code    = sidta_pkg::CHAR_ZERO + {2'b00, top_digit};
    last         = 1'b0;

    unique case (state)
      sidta_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // magnitude as unsigned, so the most negative value is fine
          bin_next     = raw[sidta_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
          neg_next     = raw[sidta_pkg::VALUE_W-1];
          bcd_next     = '0;
          bit_cnt_next = '0;
          state_next   = sidta_pkg::ST_CONV;
        end
      end
      sidta_pkg::ST_CONV: begin
        bcd_next     = {bcd_adj[sidta_pkg::BCD_W-2:0], bin[sidta_pkg::VALUE_W-1]};
        bin_next     = {bin[sidta_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == sidta_pkg::BIT_CNT_W'(sidta_pkg::VALUE_W - 1)) begin
          dig_cnt_next = sidta_pkg::DIG_CNT_W'(sidta_pkg::NUM_DIGITS);
          state_next   = sidta_pkg::ST_SKIP;
        end
      end
      sidta_pkg::ST_SKIP: begin
        // drop leading zeros, always keep the units digit
        if (top_digit == 4'd0 && dig_cnt > sidta_pkg::DIG_CNT_W'(1)) begin
          bcd_next     = {bcd[sidta_pkg::BCD_W-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 1'b1;
        end else begin
          state_next = neg ? sidta_pkg::ST_SIGN : sidta_pkg::ST_EMIT;
        end
      end
      sidta_pkg::ST_SIGN: begin
        out_valid = 1'b1;
        char_code = sidta_pkg::CHAR_MINUS;
        if (!out_stall) begin
          state_next = sidta_pkg::ST_EMIT;
        end
      end
      sidta_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        last      = (dig_cnt == sidta_pkg::DIG_CNT_W'(1));
        if (!out_stall) begin
          bcd_next     = {bcd[sidta_pkg::BCD_W-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 1'b1;
          if (dig_cnt == sidta_pkg::DIG_CNT_W'(1)) begin
            state_next = sidta_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sidta_pkg::ST_IDLE;
      end
    endcase
  end

  `SIDTA_ASSERT_NOW(a_char_range, out_valid, (char_code == sidta_pkg::CHAR_MINUS) || (char_code >= sidta_pkg::CHAR_ZERO && char_code <= sidta_pkg::CHAR_NINE), "character outside digit and minus codes")
  `SIDTA_ASSERT_NOW(a_minus_not_last, out_valid && char_code == sidta_pkg::CHAR_MINUS, !last, "minus sign marked as last")
  `SIDTA_ASSERT_NOW(a_no_overlap, !in_stall, !out_valid, "input taken while a run is pending")
  `SIDTA_ASSERT_NEXT(a_accept_quiet, in_valid && !in_stall, !out_valid && in_stall, "output or input open right after accept")
  `SIDTA_ASSERT_NEXT(a_run_ends, out_valid && last && !out_stall, !out_valid && !in_stall, "run continues after last beat")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic [sidta_pkg::CHAR_W-1:0] code;
    logic                         last;
  } char_beat_t;

  typedef struct packed {
    logic signed [sidta_pkg::VALUE_W-1:0] num;
    bit                                   drain;
  } number_item_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [sidta_pkg::VALUE_W-1:0] value = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [sidta_pkg::CHAR_W-1:0]         char_code;
  logic                                 last;

  number_item_t pending_numbers[$];
  char_beat_t   text_q[$];
  int           mismatch_cnt = 0;
  int           send_idle = 0;
  int           send_calm = 0;
  int           recv_idle = 0;
  int           recv_calm = 0;
  int           quiet_cycles = 0;

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  always #1 clk = ~clk;

  // Expected text for one number: optional sign, then digits MSB first.
  function automatic void predict_text(input logic [sidta_pkg::VALUE_W-1:0] num);
    logic [sidta_pkg::VALUE_W-1:0] mag;
    logic [3:0]                    digit[sidta_pkg::NUM_DIGITS];
    int                            n;
    char_beat_t                    beat;
    mag = num[sidta_pkg::VALUE_W-1] ? (~num + 1'b1) : num;
    n = 0;
    do begin
      digit[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < sidta_pkg::NUM_DIGITS);
    if (num[sidta_pkg::VALUE_W-1]) begin
      beat.code = sidta_pkg::CHAR_MINUS;
      beat.last = 1'b0;
      text_q.push_back(beat);
    end
    for (int d = n - 1; d >= 0; d--) begin
      beat.code = sidta_pkg::CHAR_ZERO + sidta_pkg::CHAR_W'(digit[d]);
      beat.last = (d == 0);
      text_q.push_back(beat);
    end
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("mismatch @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_number(input logic signed [sidta_pkg::VALUE_W-1:0] num,
                              input bit drain);
    number_item_t it;
    it.num = num;
    it.drain = drain;
    pending_numbers.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_idle = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_text(value);
        void'(pending_numbers.pop_front());
        send_idle = next_gap(send_calm);
      end
      if (in_valid && in_stall) begin
        // beat held until taken
      end else if (send_idle > 0) begin
        send_idle--;
        in_valid <= 1'b0;
      end else if (pending_numbers.size() != 0 &&
                   !(pending_numbers[0].drain && text_q.size() != 0)) begin
        in_valid <= 1'b1;
        value    <= pending_numbers[0].num;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    char_beat_t exp_beat;
    if (rst) begin
      out_stall <= 1'b0;
      recv_idle = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (text_q.size() == 0) begin
          note_mismatch($sformatf("unexpected char %0d last %0b", char_code, last));
        end else begin
          exp_beat = text_q.pop_front();
          if (char_code !== exp_beat.code)
            note_mismatch($sformatf("char_code exp %0d got %0d", exp_beat.code, char_code));
          if (last !== exp_beat.last)
            note_mismatch($sformatf("last exp %0b got %0b", exp_beat.last, last));
        end
      end
      if (recv_idle == 0 && $urandom_range(0, 99) < 25) recv_idle = next_gap(recv_calm);
      if (recv_idle > 0) begin
        recv_idle--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    longint lo;
    longint hi;
    longint mag;
    int     nd;
    int     pow;

    // directed: sign/digit-count edges, alternating bit patterns
    queue_number(32'sd0, 1'b0);
    queue_number(32'sd1, 1'b0);
    queue_number(-32'sd1, 1'b0);
    queue_number(32'sd9, 1'b0);
    queue_number(32'sd10, 1'b0);
    queue_number(-32'sd10, 1'b0);
    queue_number(32'sd99, 1'b0);
    queue_number(32'sd100, 1'b0);
    queue_number(32'sh7FFF_FFFF, 1'b0);
    queue_number(32'sh8000_0000, 1'b1);
    queue_number(32'sh8000_0001, 1'b0);
    queue_number(32'sd1000000000, 1'b0);
    queue_number(32'sd999999999, 1'b0);
    queue_number(-32'sd999999999, 1'b0);
    queue_number(-32'sd1000000000, 1'b0);
    queue_number(32'sh5555_5555, 1'b0);
    queue_number(32'shAAAA_AAAA, 1'b0);
    queue_number(32'sd1234567890, 1'b1);
    queue_number(-32'sd1234567890, 1'b0);
    queue_number(-32'sd5, 1'b0);
    queue_number(32'sd7, 1'b0);

    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_number($urandom, (i % 100) == 50);
      end else begin
        // uniform over digit count so short texts show up as often as long
        nd = $urandom_range(1, 10);
        pow = 1;
        for (int k = 1; k < nd; k++) pow *= 10;
        lo = (nd == 1) ? 0 : pow;
        hi = (nd == 10) ? 64'd2147483647 : longint'(pow) * 10 - 1;
        mag = $urandom_range(int'(hi), int'(lo));
        if ($urandom_range(0, 1)) begin
          if (nd == 10 && $urandom_range(0, 15) == 0) mag = 64'd2147483648;
          queue_number(sidta_pkg::VALUE_W'(-mag), (i % 100) == 50);
        end else begin
          queue_number(sidta_pkg::VALUE_W'(mag), (i % 100) == 50);
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_numbers.size() != 0 || text_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && text_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
